@@ rtl/ipv6p_pkg.sv @@
`default_nettype none

package ipv6p_pkg;

    localparam int CHAR_W        = 8;
    localparam int GROUP_W       = 16;
    localparam int NUM_GROUPS    = 8;
    localparam int GROUP_IDX_W   = 3;
    localparam int GROUP_CNT_W   = 4;
    localparam int ADDR_W        = 64;
    localparam int OCTET_W       = 8;
    localparam int DIGIT_CNT_W   = 3;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [GROUP_W-1:0] group_t;
    typedef logic [ADDR_W-1:0]  addr_half_t;
    typedef logic [OCTET_W-1:0] octet_t;

    localparam char_t CHAR_COLON  = 8'h3a;
    localparam char_t CHAR_DOT    = 8'h2e;
    localparam char_t CHAR_ZERO   = 8'h30;
    localparam char_t CHAR_NINE   = 8'h39;
    localparam char_t CHAR_LOW_A  = 8'h61;
    localparam char_t CHAR_LOW_F  = 8'h66;
    localparam char_t CHAR_UP_A   = 8'h41;
    localparam char_t CHAR_UP_F   = 8'h46;

    localparam logic [4:0] HEX_NONE       = 5'd16;
    localparam logic [4:0] HEX_DEC_MAX    = 5'd9;
    localparam logic [DIGIT_CNT_W-1:0] MAX_HEX_DIGITS = 3'd4;
    localparam logic [GROUP_CNT_W-1:0] DOTTED_MAX_GROUPS = 4'd6;
    localparam logic [GROUP_CNT_W-1:0] ALL_GROUPS = 4'd8;
    localparam logic [11:0] OCTET_MAX = 12'd255;

    // value of a hex digit, or HEX_NONE for any other character
    function automatic logic [4:0] hex_of(input char_t c);
        logic [4:0] d;
        d = HEX_NONE;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d = 5'(c - CHAR_ZERO);
        end
        else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F)
        begin
            d = 5'(c - CHAR_LOW_A) + 5'd10;
        end
        else if (c >= CHAR_UP_A && c <= CHAR_UP_F)
        begin
            d = 5'(c - CHAR_UP_A) + 5'd10;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ipv6p_if.sv @@
`default_nettype none

interface ipv6p_text_if;
    import ipv6p_pkg::*;

    logic  valid;
    logic  ready;
    char_t char_code;
    logic  has_char;
    logic  last;

    modport source (output valid, output char_code, output has_char, output last,
                    input ready);
    modport sink   (input valid, input char_code, input has_char, input last,
                    output ready);
endinterface

interface ipv6p_result_if;
    import ipv6p_pkg::*;

    logic       valid;
    logic       ready;
    addr_half_t addr_high;
    addr_half_t addr_low;
    logic       invalid;

    modport source (output valid, output addr_high, output addr_low, output invalid,
                    input ready);
    modport sink   (input valid, input addr_high, input addr_low, input invalid,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/ipv6_address_text_parser_top.sv @@
// the result of a string is registered and valid in the cycle after its last character is accepted
// throughput: one character per cycle while the result is not stalled, set by the parser state update
// a new character is taken while a finished result waits, unless the result is stalled
// reset: asynchronous, active low; clears the parser control state and the result valid flag
`default_nettype none

module ipv6_address_text_parser_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    ipv6p_text_if.sink         text,
    ipv6p_result_if.source     result
);
    import ipv6p_pkg::*;

    group_t                   group_reg [NUM_GROUPS];
    logic [GROUP_CNT_W-1:0]   groups_reg;
    logic [GROUP_CNT_W-1:0]   zr_at_reg;
    logic                     zr_seen_reg;
    group_t                   tok_val_reg;
    logic [DIGIT_CNT_W-1:0]   tok_digits_reg;
    logic                     dotted_reg;
    logic [1:0]               octet_num_reg;
    octet_t                   octet_val_reg;
    octet_t                   octets_reg [3];
    logic                     prev_colon_reg;
    logic                     not_dec_reg;
    logic                     failed_reg;

    group_t                   group_next [NUM_GROUPS];
    logic [GROUP_CNT_W-1:0]   groups_next;
    logic [GROUP_CNT_W-1:0]   zr_at_next;
    logic                     zr_seen_next;
    group_t                   tok_val_next;
    logic [DIGIT_CNT_W-1:0]   tok_digits_next;
    logic                     dotted_next;
    logic [1:0]               octet_num_next;
    octet_t                   octet_val_next;
    octet_t                   octets_next [3];
    logic                     prev_colon_next;
    logic                     not_dec_next;
    logic                     failed_next;

    logic                     res_valid_reg;
    addr_half_t               res_high_reg;
    addr_half_t               res_low_reg;
    logic                     res_invalid_reg;
    addr_half_t               res_high_next;
    addr_half_t               res_low_next;
    logic                     res_invalid_next;

    logic                     accept;

    assign text.ready = !res_valid_reg || result.ready;
    assign accept     = text.valid && text.ready;

    always_comb
    begin
        logic [4:0]             hex;
        logic [3:0]             dig;
        logic [11:0]            ov;
        logic [9:0]             dec;
        group_t                 fg [NUM_GROUPS];
        group_t                 w [NUM_GROUPS];
        logic [GROUP_CNT_W-1:0] g;
        logic [GROUP_CNT_W-1:0] after;
        logic                   f_failed;
        logic [GROUP_IDX_W-1:0] src;

        for (int i = 0; i < NUM_GROUPS; i++)
        begin
            group_next[i] = group_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            octets_next[i] = octets_reg[i];
        end
        groups_next     = groups_reg;
        zr_at_next      = zr_at_reg;
        zr_seen_next    = zr_seen_reg;
        tok_val_next    = tok_val_reg;
        tok_digits_next = tok_digits_reg;
        dotted_next     = dotted_reg;
        octet_num_next  = octet_num_reg;
        octet_val_next  = octet_val_reg;
        prev_colon_next = prev_colon_reg;
        not_dec_next    = not_dec_reg;
        failed_next     = failed_reg;

        hex = hex_of(text.char_code);
        dig = text.char_code[3:0];
        ov  = 12'(octet_val_reg) * 12'd10 + 12'(dig);
        // token nibbles as decimal digits, last digit in the low nibble
        unique case (tok_digits_reg)
            3'd1:    dec = 10'(tok_val_reg[3:0]);
            3'd2:    dec = 10'(tok_val_reg[7:4]) * 10'd10 + 10'(tok_val_reg[3:0]);
            3'd3:    dec = 10'(tok_val_reg[11:8]) * 10'd100
                         + 10'(tok_val_reg[7:4]) * 10'd10 + 10'(tok_val_reg[3:0]);
            default: dec = 10'd1023;
        endcase

        if (accept && text.has_char && !failed_reg)
        begin
            if (dotted_reg)
            begin
                if (text.char_code >= CHAR_ZERO && text.char_code <= CHAR_NINE)
                begin
                    if ((tok_digits_reg != '0 && octet_val_reg == '0) || ov > OCTET_MAX)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        octet_val_next  = ov[7:0];
                        tok_digits_next = 3'd1;
                    end
                end
                else if (text.char_code == CHAR_DOT)
                begin
                    if (tok_digits_reg == '0 || octet_num_reg == 2'd3)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        if (octet_num_reg == 2'd1)
                        begin
                            octets_next[1] = octet_val_reg;
                        end
                        else
                        begin
                            octets_next[2] = octet_val_reg;
                        end
                        octet_num_next  = octet_num_reg + 2'd1;
                        octet_val_next  = '0;
                        tok_digits_next = '0;
                    end
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
            else if (hex != HEX_NONE)
            begin
                if ((prev_colon_reg && groups_reg == '0 && !zr_seen_reg)
                    || tok_digits_reg >= MAX_HEX_DIGITS)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    tok_val_next    = {tok_val_reg[11:0], hex[3:0]};
                    tok_digits_next = tok_digits_reg + 3'd1;
                    if (hex > HEX_DEC_MAX)
                    begin
                        not_dec_next = 1'b1;
                    end
                    prev_colon_next = 1'b0;
                end
            end
            else if (text.char_code == CHAR_COLON)
            begin
                if (prev_colon_reg)
                begin
                    if (zr_seen_reg)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        zr_seen_next = 1'b1;
                        zr_at_next   = groups_reg;
                    end
                end
                else
                begin
                    if (tok_digits_reg != '0)
                    begin
                        if (groups_reg >= ALL_GROUPS)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            group_next[groups_reg[GROUP_IDX_W-1:0]] = tok_val_reg;
                            groups_next = groups_reg + 4'd1;
                        end
                        tok_val_next    = '0;
                        tok_digits_next = '0;
                        not_dec_next    = 1'b0;
                    end
                    prev_colon_next = 1'b1;
                end
            end
            else if (text.char_code == CHAR_DOT)
            begin
                if (tok_digits_reg == '0 || not_dec_reg || groups_reg > DOTTED_MAX_GROUPS
                    || dec > 10'(OCTET_MAX)
                    || (tok_digits_reg >= 3'd2 && tok_digits_reg == 3'd2
                        && tok_val_reg[7:4] == '0)
                    || (tok_digits_reg == 3'd3 && tok_val_reg[11:8] == '0))
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    octets_next[0]  = dec[7:0];
                    dotted_next     = 1'b1;
                    octet_num_next  = 2'd1;
                    octet_val_next  = '0;
                    tok_digits_next = '0;
                    tok_val_next    = '0;
                    prev_colon_next = 1'b0;
                end
            end
            else
            begin
                failed_next = 1'b1;
            end
        end

        // end of string: close the last token and expand the zero run
        for (int i = 0; i < NUM_GROUPS; i++)
        begin
            fg[i] = group_next[i];
            w[i]  = '0;
        end
        g        = groups_next;
        f_failed = failed_next;
        after    = '0;
        src      = '0;
        if (!f_failed)
        begin
            if (dotted_next)
            begin
                if (octet_num_next == 2'd3 && tok_digits_next != '0)
                begin
                    fg[g[GROUP_IDX_W-1:0]]        = {octets_next[0], octets_next[1]};
                    fg[g[GROUP_IDX_W-1:0] + 3'd1] = {octets_next[2], octet_val_next};
                    g = g + 4'd2;
                end
                else
                begin
                    f_failed = 1'b1;
                end
            end
            else if (tok_digits_next != '0)
            begin
                if (g >= ALL_GROUPS)
                begin
                    f_failed = 1'b1;
                end
                else
                begin
                    fg[g[GROUP_IDX_W-1:0]] = tok_val_next;
                    g = g + 4'd1;
                end
            end
            else if (!(prev_colon_next && zr_seen_next && zr_at_next == g))
            begin
                f_failed = 1'b1;
            end
        end
        if (!f_failed)
        begin
            if (zr_seen_next)
            begin
                if (g >= ALL_GROUPS || zr_at_next > g)
                begin
                    f_failed = 1'b1;
                end
                else
                begin
                    after = g - zr_at_next;
                    for (int i = 0; i < NUM_GROUPS; i++)
                    begin
                        // groups after the run are right-aligned
                        src = GROUP_IDX_W'(i) + g[GROUP_IDX_W-1:0];
                        if (GROUP_CNT_W'(i) < zr_at_next)
                        begin
                            w[i] = fg[i];
                        end
                        else if (GROUP_CNT_W'(i) >= ALL_GROUPS - after)
                        begin
                            w[i] = fg[src];
                        end
                    end
                end
            end
            else if (g != ALL_GROUPS)
            begin
                f_failed = 1'b1;
            end
            else
            begin
                for (int i = 0; i < NUM_GROUPS; i++)
                begin
                    w[i] = fg[i];
                end
            end
        end
        if (f_failed)
        begin
            for (int i = 0; i < NUM_GROUPS; i++)
            begin
                w[i] = '0;
            end
        end
        res_high_next    = {w[0], w[1], w[2], w[3]};
        res_low_next     = {w[4], w[5], w[6], w[7]};
        res_invalid_next = f_failed;

        if (accept && text.last)
        begin
            groups_next     = '0;
            zr_at_next      = '0;
            zr_seen_next    = 1'b0;
            tok_val_next    = '0;
            tok_digits_next = '0;
            dotted_next     = 1'b0;
            octet_num_next  = '0;
            octet_val_next  = '0;
            prev_colon_next = 1'b0;
            not_dec_next    = 1'b0;
            failed_next     = 1'b0;
        end
    end

    // group store and octet bytes are read only after being written in the same string
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_GROUPS; i++)
        begin
            group_reg[i] <= group_next[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            octets_reg[i] <= octets_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_reg     <= '0;
            zr_at_reg      <= '0;
            zr_seen_reg    <= 1'b0;
            tok_val_reg    <= '0;
            tok_digits_reg <= '0;
            dotted_reg     <= 1'b0;
            octet_num_reg  <= '0;
            octet_val_reg  <= '0;
            prev_colon_reg <= 1'b0;
            not_dec_reg    <= 1'b0;
            failed_reg     <= 1'b0;
        end
        else
        begin
            groups_reg     <= groups_next;
            zr_at_reg      <= zr_at_next;
            zr_seen_reg    <= zr_seen_next;
            tok_val_reg    <= tok_val_next;
            tok_digits_reg <= tok_digits_next;
            dotted_reg     <= dotted_next;
            octet_num_reg  <= octet_num_next;
            octet_val_reg  <= octet_val_next;
            prev_colon_reg <= prev_colon_next;
            not_dec_reg    <= not_dec_next;
            failed_reg     <= failed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept && text.last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && text.last)
        begin
            res_high_reg    <= res_high_next;
            res_low_reg     <= res_low_next;
            res_invalid_reg <= res_invalid_next;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.addr_high = res_high_reg;
    assign result.addr_low  = res_low_reg;
    assign result.invalid   = res_invalid_reg;

endmodule

`default_nettype wire

@@ rtl/ipv6p_checker.sv @@
`default_nettype none

module ipv6p_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 text_valid,
    input wire logic                 text_ready,
    input wire logic                 text_last,
    input wire logic                 result_valid,
    input wire logic                 result_ready,
    input wire logic                 result_invalid,
    input wire ipv6p_pkg::addr_half_t result_addr_high,
    input wire ipv6p_pkg::addr_half_t result_addr_low
);
    import ipv6p_pkg::*;

    // a stalled result transaction keeps its address
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_addr_high)
            && $stable(result_addr_low) && $stable(result_invalid))
        else $error("stalled result changed");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_invalid |-> result_addr_high == '0 && result_addr_low == '0)
        else $error("rejected text with non-zero address");

    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready && text_last |=> result_valid)
        else $error("no result after last character");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(text_valid && text_ready && text_last))
        else $error("result without a last character");

endmodule

bind ipv6_address_text_parser_top ipv6p_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .text_valid       (text.valid),
    .text_ready       (text.ready),
    .text_last        (text.last),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_invalid   (result.invalid),
    .result_addr_high (result.addr_high),
    .result_addr_low  (result.addr_low)
);

`default_nettype wire
